### hw/rtl/cpa_pkg.sv
// ----------------------------------------------------------------------------
// cpa_pkg
// Shared types and constants of the chunk pool allocator.
// ----------------------------------------------------------------------------
package cpa_pkg;

  localparam int DEF_MAX_POOLS  = 8;
  localparam int DEF_MAX_CHUNKS = 256;

  localparam int CFG_DATA_W = 17;

  localparam logic CFG_MIN_ALIGNMENT = 1'b0;
  localparam logic CFG_POOL_BYTES    = 1'b1;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_NO_SLOT  = 2'd1;
  localparam logic [1:0] ST_BAD_SLOT = 2'd2;
  localparam logic [1:0] ST_REL_FULL = 2'd3;

  localparam logic [8:0]  ALIGN_RESET = 9'd256;
  localparam logic [16:0] BYTES_RESET = 17'd65536;
  localparam logic [16:0] BYTES_MAX   = 17'd65536;

  typedef struct packed {
    logic        operation;
    logic [16:0] request_bytes;
    logic [2:0]  release_pool;
    logic [15:0] release_offset;
  } item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [2:0]  granted_pool;
    logic [15:0] granted_offset;
    logic [16:0] chunk_bytes;
    logic        pool_created;
  } result_t;

  // controller -> datapath
  typedef struct packed {
    logic load;
    logic scan_step;
    logic sel;
    logic round_step;
    logic fill_init;
    logic fill_step;
    logic pop;
    logic emit_alloc;
    logic emit_full;
    logic emit_rel;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic scan_last;
    logic found;
    logic slots_full;
    logic round_done;
    logic fill_last;
  } stat_t;

endpackage

### hw/rtl/chunk_pool_allocator_top.sv
// ----------------------------------------------------------------------------
// chunk_pool_allocator_top
// Size-class chunk allocator over MAX_POOLS pools with per-pool offset stacks.
// ----------------------------------------------------------------------------
// Release: the release state registers the result and raises the done strobe.
// Allocate from an existing pool: scan (one pool per cycle), then select,
//   stack read, result register and strobe.
// Allocate creating a pool: adds size rounding after select, then the fill
//   pushing the pool's chunks (at most MAX_CHUNKS).
// One beat in flight at a time; results cannot be stalled by the receiver.
// Reset clears pool use flags and the pool count; no clearing pass is needed.
// ----------------------------------------------------------------------------
module chunk_pool_allocator_top
  import cpa_pkg::*;
#(
  parameter int MAX_POOLS  = DEF_MAX_POOLS,
  parameter int MAX_CHUNKS = DEF_MAX_CHUNKS
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic                  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  start,
  input  item_t                 item,
  output logic                  busy,
  output logic                  done,
  output result_t               result
);

  cmd_t  cmd;
  stat_t stat;

  // controller sequences scan -> decide -> (create) -> pop -> grant, or release
  cpa_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .start_op (item.operation),
    .stat     (stat),
    .cmd      (cmd),
    .busy     (busy)
  );

  // datapath holds pool tables, the offset stack RAM and the result register
  cpa_datapath #(
    .MAX_POOLS  (MAX_POOLS),
    .MAX_CHUNKS (MAX_CHUNKS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .item      (item),
    .cmd       (cmd),
    .stat      (stat),
    .result    (result),
    .done      (done)
  );

  // a beat is only ever produced by a sequence that held busy
  a_done_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy))
    else $error("result strobe without a beat in flight");

  // accepted beat must raise busy
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("accepted beat did not raise busy");

  // a good grant or release always names a pool with a real chunk size
  a_ok_chunk: assert property (@(posedge clk) disable iff (rst)
    (done && result.status == ST_OK) |-> (result.chunk_bytes != 17'd0))
    else $error("ok result with zero chunk size");

  // errors carry zero payload
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    (done && result.status != ST_OK) |->
      (result.chunk_bytes == 17'd0 && result.granted_offset == 16'd0 &&
       result.pool_created == 1'b0))
    else $error("error result with non-zero payload");

endmodule

### hw/rtl/cpa_ctrl.sv
// ----------------------------------------------------------------------------
// cpa_ctrl
// Sequencer: pool scan, pool creation, stack pop and release push.
// ----------------------------------------------------------------------------
module cpa_ctrl
  import cpa_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  start,
  input  logic  start_op,
  input  stat_t stat,
  output cmd_t  cmd,
  output logic  busy
);

  typedef enum logic [2:0] {
    S_IDLE, S_SCAN, S_DECIDE, S_ROUND, S_FILL, S_POP, S_GRANT, S_RELEASE
  } state_t;

  state_t state, state_next;

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (start) begin
          cmd.load   = 1'b1;
          state_next = start_op ? S_RELEASE : S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.scan_step = 1'b1;
        if (stat.scan_last) state_next = S_DECIDE;
      end
      S_DECIDE: begin
        if (stat.found) begin
          cmd.sel    = 1'b1;
          state_next = S_POP;
        end else if (stat.slots_full) begin
          cmd.emit_full = 1'b1;
          state_next    = S_IDLE;
        end else begin
          cmd.sel    = 1'b1;
          state_next = S_ROUND;
        end
      end
      S_ROUND: begin
        if (stat.round_done) begin
          cmd.fill_init = 1'b1;
          state_next    = S_FILL;
        end else begin
          cmd.round_step = 1'b1;
        end
      end
      S_FILL: begin
        cmd.fill_step = 1'b1;
        if (stat.fill_last) state_next = S_POP;
      end
      S_POP: begin
        cmd.pop    = 1'b1;
        state_next = S_GRANT;
      end
      S_GRANT: begin
        cmd.emit_alloc = 1'b1;
        state_next     = S_IDLE;
      end
      S_RELEASE: begin
        cmd.emit_rel = 1'b1;
        state_next   = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      busy  <= 1'b0;
    end else begin
      state <= state_next;
      busy  <= (state_next != S_IDLE);
    end
  end

endmodule

### hw/rtl/cpa_datapath.sv
// ----------------------------------------------------------------------------
// cpa_datapath
// Pool tables, offset stack memory, size rounding and result register.
// ----------------------------------------------------------------------------
module cpa_datapath
  import cpa_pkg::*;
#(
  parameter int MAX_POOLS  = DEF_MAX_POOLS,
  parameter int MAX_CHUNKS = DEF_MAX_CHUNKS
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic                  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  item_t                 item,
  input  cmd_t                  cmd,
  output stat_t                 stat,
  output result_t               result,
  output logic                  done
);

  localparam int PW    = (MAX_POOLS > 1) ? $clog2(MAX_POOLS) : 1;
  localparam int NCW   = $clog2(MAX_POOLS + 1);
  localparam int KW    = $clog2(MAX_CHUNKS);
  localparam int CW    = $clog2(MAX_CHUNKS + 1);
  localparam int DEPTH = MAX_POOLS * MAX_CHUNKS;
  localparam int AW    = $clog2(DEPTH);

  // configuration
  logic [8:0]  align_r;
  logic [16:0] bytes_r;
  logic [16:0] align_eff, bytes_eff;

  always_ff @(posedge clk) begin
    if (rst) begin
      align_r <= ALIGN_RESET;
      bytes_r <= BYTES_RESET;
    end else if (cfg_we) begin
      if (cfg_index == CFG_MIN_ALIGNMENT) align_r <= cfg_data[8:0];
      else                                bytes_r <= cfg_data;
    end
  end

  assign align_eff = (align_r == 9'd0) ? 17'd1 : {8'd0, align_r};
  assign bytes_eff = (bytes_r == 17'd0) ? 17'd1 :
                     (bytes_r > BYTES_MAX) ? BYTES_MAX : bytes_r;

  // latched request
  logic        rel_range_r, created_r;
  logic [16:0] req_r;
  logic [2:0]  rel_pool_r;
  logic [15:0] rel_off_r;
  logic [16:0] req_clamped;

  assign req_clamped = (item.request_bytes == 17'd0) ? 17'd1 :
                       (item.request_bytes > BYTES_MAX) ? BYTES_MAX : item.request_bytes;

  // pool tables
  logic              in_use     [MAX_POOLS];
  logic [16:0]       chunk_size [MAX_POOLS];
  logic [CW-1:0]     free_cnt   [MAX_POOLS];
  logic [NCW-1:0]    pools_created;
  logic [PW-1:0]     idx;
  logic              iu_rd;
  logic [16:0]       cs_rd;
  logic [CW-1:0]     fc_rd;

  assign iu_rd = in_use[idx];
  assign cs_rd = chunk_size[idx];
  assign fc_rd = free_cnt[idx];

  // scan best
  logic          best_found;
  logic [PW-1:0] best_idx;
  logic [16:0]   best_size;
  logic          cand;

  assign cand = iu_rd && (fc_rd != '0) && (cs_rd >= req_r) &&
                (!best_found || (cs_rd < best_size));

  // creation
  logic [16:0]   pw;
  logic [16:0]   chunk_r;
  logic [17:0]   acc;
  logic [17:0]   acc_next;
  logic [KW-1:0] k;

  assign acc_next = acc + {1'b0, chunk_r};

  // release checks
  logic rel_bad, rel_full;
  assign rel_bad  = !rel_range_r || !iu_rd;
  assign rel_full = (32'(fc_rd) >= MAX_CHUNKS);

  logic [1:0] err_status;
  assign err_status = cmd.emit_full ? ST_NO_SLOT :
                      rel_bad       ? ST_BAD_SLOT : ST_REL_FULL;

  assign stat.scan_last  = (32'(idx) == MAX_POOLS - 1);
  assign stat.found      = best_found;
  assign stat.slots_full = (32'(pools_created) >= MAX_POOLS);
  assign stat.round_done = (pw >= req_r);
  assign stat.fill_last  = (32'(k) == MAX_CHUNKS - 1) || (acc_next >= {1'b0, bytes_eff});

  // stack memory
  logic [15:0]   stack_mem [DEPTH];
  logic          mem_we;
  logic [AW-1:0] mem_waddr, mem_raddr;
  logic [15:0]   mem_wdata, rd_data;
  logic          push_ok;

  assign push_ok   = cmd.emit_rel && !rel_bad && !rel_full;
  assign mem_we    = cmd.fill_step || push_ok;
  assign mem_waddr = cmd.fill_step
                     ? AW'(32'(idx) * MAX_CHUNKS + 32'(k))
                     : AW'(32'(idx) * MAX_CHUNKS + 32'(fc_rd));
  assign mem_wdata = cmd.fill_step ? acc[15:0] : rel_off_r;
  assign mem_raddr = AW'(32'(idx) * MAX_CHUNKS + 32'(fc_rd) - 32'd1);

  always_ff @(posedge clk) begin
    if (mem_we) stack_mem[mem_waddr] <= mem_wdata;
    if (cmd.pop) rd_data <= stack_mem[mem_raddr];
  end

  // request latch, scan, rounding, fill
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_r       <= req_clamped;
      rel_pool_r  <= item.release_pool;
      rel_off_r   <= item.release_offset;
      rel_range_r <= (32'(item.release_pool) < MAX_POOLS);
      created_r   <= 1'b0;
      best_found  <= 1'b0;
      pw          <= 17'd1;
      if (item.operation && (32'(item.release_pool) < MAX_POOLS))
        idx <= PW'(item.release_pool);
      else
        idx <= '0;
    end
    if (cmd.scan_step) begin
      if (cand) begin
        best_found <= 1'b1;
        best_idx   <= idx;
        best_size  <= cs_rd;
      end
      idx <= idx + PW'(1);
    end
    if (cmd.sel) idx <= best_found ? best_idx : PW'(pools_created);
    if (cmd.round_step) pw <= pw << 1;
    if (cmd.fill_init) begin
      chunk_r <= (pw >= align_eff) ? pw : align_eff;
      acc     <= '0;
      k       <= '0;
    end
    if (cmd.fill_step) begin
      acc <= acc_next;
      k   <= k + KW'(1);
      if (stat.fill_last) created_r <= 1'b1;
    end
  end

  // table updates
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < MAX_POOLS; i++) in_use[i] <= 1'b0;
      pools_created <= '0;
    end else if (cmd.fill_step && stat.fill_last) begin
      in_use[idx]   <= 1'b1;
      pools_created <= pools_created + NCW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.fill_step && stat.fill_last) begin
      chunk_size[idx] <= chunk_r;
      free_cnt[idx]   <= CW'(k) + CW'(1);
    end else if (cmd.pop) begin
      free_cnt[idx] <= fc_rd - CW'(1);
    end else if (push_ok) begin
      free_cnt[idx] <= fc_rd + CW'(1);
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= cmd.emit_alloc || cmd.emit_full || cmd.emit_rel;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_full || (cmd.emit_rel && (rel_bad || rel_full))) begin
      result <= '{status: err_status, granted_pool: 3'd0, granted_offset: 16'd0,
                  chunk_bytes: 17'd0, pool_created: 1'b0};
    end else if (cmd.emit_alloc) begin
      result.status         <= ST_OK;
      result.granted_pool   <= 3'(32'(idx));
      result.granted_offset <= rd_data;
      result.chunk_bytes    <= cs_rd;
      result.pool_created   <= created_r;
    end else if (cmd.emit_rel) begin
      result.status         <= ST_OK;
      result.granted_pool   <= rel_pool_r;
      result.granted_offset <= rel_off_r;
      result.chunk_bytes    <= cs_rd;
      result.pool_created   <= 1'b0;
    end
  end

endmodule
